// ----- rtl/core/igfr_pkg.sv -----
// igfr_pkg: shared types and constants for the idle gap frame receiver.
// Used by igfr_cfg and idle_gap_frame_receiver; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package igfr_pkg;

	// frame store depth default
	localparam int BUFFER_DEPTH_DEF = 16;

	// idle count saturates here
	localparam int IDLE_W = 8;
	localparam logic [IDLE_W-1:0] IDLE_MAX = '1;
	localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = IDLE_W'(10);

	// APB register map
	localparam int APB_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-3:0] REG_IDLE_LIMIT = '0;

	typedef enum logic [1:0] {
		REQ_BYTE = 2'd0,
		REQ_TICK = 2'd1,
		REQ_READ = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_STREAM = 2'b10
	} state_t;

endpackage : igfr_pkg

`default_nettype wire

// ----- rtl/core/idle_gap_frame_receiver.sv -----
// Idle gap frame receiver: collects bytes into a frame store, closes the frame after
// idle_limit ticks with no byte, and streams the frame out on a read request.
// Byte and tick transactions never raise busy. A read of a complete frame of N bytes holds
// busy while the frame streams out (one store read port, one byte a cycle); each result is
// registered behind its store read (rdata_s1, res_vld_s1). A read with no frame
// gives one not-ready result the cycle after accept. Reset clears all control; store is not reset.
`timescale 1ns / 1ps
`default_nettype none

module idle_gap_frame_receiver #(
	parameter int BUFFER_DEPTH = igfr_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// command channel
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       req_type,
	input  wire logic [7:0]                       rx_byte,
	// result channel, one result per strobe cycle, no backpressure
	output logic                                  strobe,
	output logic                                  frame_ready,
	output logic      [7:0]                       data_byte,
	output logic                                  last_byte,
	// configuration
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [igfr_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [igfr_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [igfr_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready
);
	import igfr_pkg::*;

	localparam int IDX_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

	// configuration register
	logic [IDLE_W-1:0] idle_limit;

	igfr_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.idle_limit (idle_limit)
	);

	// control state
	state_t            state_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDLE_W-1:0] idle_q;
	logic              done_q;
	logic [IDX_W-1:0]  rd_ptr_q;

	// result stage, aligned with the store read data
	logic              res_vld_s1;
	logic              res_rdy_s1;
	logic              res_last_s1;
	logic [7:0]        rdata_s1;

	// frame store: one write port (byte append), one read port (streaming)
	logic [7:0]        frame_store [BUFFER_DEPTH];

	req_t              req;
	logic              accept;
	logic              have_frame;
	logic              mem_we;
	logic              mem_re;
	logic              rd_last;
	logic [IDLE_W-1:0] idle_inc;

	assign req        = req_t'(req_type);
	assign busy       = (state_q == ST_STREAM);
	assign accept     = start && !busy;
	assign have_frame = done_q && (fill_q != '0);

	// appends happen only while idle and reads only while streaming,
	// so busy keeps the two ports off the same entry
	assign mem_we  = accept && (req == REQ_BYTE) && (fill_q < DEPTH_CNT);
	assign mem_re  = (state_q == ST_STREAM);
	assign rd_last = (CNT_W'(rd_ptr_q) + CNT_W'(1)) == fill_q;

	assign idle_inc = (idle_q == IDLE_MAX) ? IDLE_MAX : idle_q + IDLE_W'(1);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_store[fill_q[IDX_W-1:0]] <= rx_byte;
		end
		if (mem_re) begin
			rdata_s1 <= frame_store[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			idle_q      <= '0;
			done_q      <= 1'b0;
			rd_ptr_q    <= '0;
			res_vld_s1  <= 1'b0;
			res_rdy_s1  <= 1'b0;
			res_last_s1 <= 1'b0;
		end else begin
			res_vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req)
							REQ_BYTE: begin
								if (mem_we) begin
									fill_q <= fill_q + CNT_W'(1);
								end
								idle_q <= '0;
							end
							REQ_TICK: begin
								idle_q <= idle_inc;
								if (fill_q != '0 && idle_inc >= idle_limit) begin
									done_q <= 1'b1;
								end
							end
							REQ_READ: begin
								if (have_frame) begin
									state_q  <= ST_STREAM;
									rd_ptr_q <= '0;
								end else begin
									// not-ready response: single result
									res_vld_s1  <= 1'b1;
									res_rdy_s1  <= 1'b0;
									res_last_s1 <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_STREAM: begin
					res_vld_s1  <= 1'b1;
					res_rdy_s1  <= 1'b1;
					res_last_s1 <= rd_last;
					rd_ptr_q    <= rd_ptr_q + IDX_W'(1);
					if (rd_last) begin
						// store empties as the final read issues
						state_q <= ST_IDLE;
						fill_q  <= '0;
						done_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe      = res_vld_s1;
	assign frame_ready = res_rdy_s1;
	assign last_byte   = res_last_s1;
	assign data_byte   = res_rdy_s1 ? rdata_s1 : 8'd0;

	// never more bytes held than the store has entries
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_CNT)
		else $error("fill count beyond store depth");

	// streaming only ever runs over a non-empty frame
	a_stream_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STREAM |-> fill_q != '0)
		else $error("streaming an empty store");

	// a read with no complete frame answers with one not-ready result
	a_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req == REQ_READ && !have_frame |=> strobe && !frame_ready && last_byte)
		else $error("missing not-ready result");

	// first frame byte follows in the cycle after streaming starts
	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |=> strobe && frame_ready)
		else $error("frame byte did not follow stream start");

	// the final frame byte leaves an emptied store behind
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && frame_ready && last_byte |-> fill_q == '0 && !done_q && !busy)
		else $error("store not emptied after last byte");

endmodule : idle_gap_frame_receiver

`default_nettype wire

// ----- rtl/core/igfr_cfg.sv -----
// igfr_cfg: APB register slice holding the idle limit.
// Depends on igfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module igfr_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [igfr_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [igfr_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [igfr_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready,
	output logic      [igfr_pkg::IDLE_W-1:0]      idle_limit
);
	import igfr_pkg::*;

	logic [CFG_ADDR_W-3:0] reg_idx;
	logic                  wr_en;
	logic [IDLE_W-1:0]     idle_limit_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= IDLE_LIMIT_RST;
		end else if (wr_en && reg_idx == REG_IDLE_LIMIT) begin
			idle_limit_q <= pwdata[IDLE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_IDLE_LIMIT) begin
			prdata = APB_DATA_W'(idle_limit_q);
		end
	end

	assign idle_limit = idle_limit_q;

endmodule : igfr_cfg

`default_nettype wire

// ----- verif/tb.sv -----
// tb: self-checking bench for idle_gap_frame_receiver (command port, result strobe, APB config).
// Depends on rtl/core/igfr_pkg.sv, rtl/core/igfr_cfg.sv and rtl/core/idle_gap_frame_receiver.sv; reads no files.
`timescale 1ns / 1ps

// Tracks the receiver's frame state and keeps the byte stream each read should return.
class frame_scoreboard;
	typedef struct packed {
		logic       ready;
		logic [7:0] data;
		logic       last;
	} frame_out_t;

	localparam int DEPTH = igfr_pkg::BUFFER_DEPTH_DEF;

	logic [7:0]                   held_bytes [DEPTH];
	int unsigned                  held_count;
	logic [igfr_pkg::IDLE_W-1:0]  quiet_ticks;
	logic                         frame_closed;
	logic [igfr_pkg::IDLE_W-1:0]  gap_limit;
	frame_out_t                   frame_out_q [$];

	int unsigned errors;
	int unsigned n_results;
	int unsigned n_frames;
	int unsigned n_dropped;
	int unsigned n_not_ready;

	function new();
		held_count   = 0;
		quiet_ticks  = '0;
		frame_closed = 1'b0;
		gap_limit    = igfr_pkg::IDLE_LIMIT_RST;
		errors       = 0;
		n_results    = 0;
		n_frames     = 0;
		n_dropped    = 0;
		n_not_ready  = 0;
	endfunction

	function void set_gap_limit(logic [7:0] v);
		gap_limit = v;
	endfunction

	function int unsigned pending();
		return frame_out_q.size();
	endfunction

	// Advance the frame state by one accepted transaction.
	function void absorb_command(igfr_pkg::req_t kind, logic [7:0] b);
		int unsigned k;
		case (kind)
			igfr_pkg::REQ_BYTE: begin
				if (held_count < DEPTH) begin
					held_bytes[held_count] = b;
					held_count++;
				end else begin
					n_dropped++;
				end
				quiet_ticks = '0;
			end
			igfr_pkg::REQ_TICK: begin
				if (quiet_ticks != igfr_pkg::IDLE_MAX)
					quiet_ticks++;
				if (held_count > 0 && quiet_ticks >= gap_limit)
					frame_closed = 1'b1;
			end
			igfr_pkg::REQ_READ: begin
				if (!frame_closed || held_count == 0) begin
					frame_out_q.push_back('{ready: 1'b0, data: 8'h00, last: 1'b1});
					n_not_ready++;
				end else begin
					for (k = 0; k < held_count; k++)
						frame_out_q.push_back('{ready: 1'b1, data: held_bytes[k],
							last: (k + 1 == held_count)});
					n_frames++;
					frame_closed = 1'b0;
					held_count   = 0;
				end
			end
			default: ;
		endcase
	endfunction

	task report_mismatch(string what);
		errors++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	task check_frame_result(logic ready, logic [7:0] data, logic last);
		frame_out_t want;
		n_results++;
		if (frame_out_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result ready=%0b data=%02h last=%0b",
				ready, data, last));
		end else begin
			want = frame_out_q.pop_front();
			if (ready !== want.ready)
				report_mismatch($sformatf("frame_ready %0b, want %0b", ready, want.ready));
			if (data !== want.data)
				report_mismatch($sformatf("data_byte %02h, want %02h", data, want.data));
			if (last !== want.last)
				report_mismatch($sformatf("last_byte %0b, want %0b", last, want.last));
		end
	endtask
endclass

module tb;
	import igfr_pkg::*;

	// cycles with no transaction and no result before the run is declared hung;
	// worst legit quiet stretch is a random send_cmd gap or a config pause, well under this
	localparam int WATCHDOG_LIMIT = 400;
	// a read result comes in the cycle after the last busy cycle; the rest is margin
	localparam int DRAIN_CYCLES   = 6;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   start    = 1'b0;
	logic [1:0]             req_type = REQ_NONE;
	logic [7:0]             rx_byte  = 8'h00;
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [CFG_ADDR_W-1:0]  paddr    = '0;
	logic [APB_DATA_W-1:0]  pwdata   = '0;
	logic                   busy;
	logic                   strobe;
	logic                   frame_ready;
	logic [7:0]             data_byte;
	logic                   last_byte;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	frame_scoreboard sb = new();

	int unsigned idle_cycles   = 0;
	int unsigned n_commands    = 0; // accepted, excluding the ignored request code
	int unsigned n_settings    = 0;
	bit          gaps_on       = 1'b0;
	logic [7:0]  cur_limit     = IDLE_LIMIT_RST;

	always #2 clk = ~clk;

	idle_gap_frame_receiver u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.rx_byte     (rx_byte),
		.strobe      (strobe),
		.frame_ready (frame_ready),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// Result monitor: no backpressure, so every strobe cycle is one result.
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_frame_result(frame_ready, data_byte, last_byte);
	end

	// Watchdog: any accepted transaction, result or APB select resets the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Watchdog: no activity for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, sb.pending());
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Present one transaction, optionally after a random idle burst, and hold it
	// until the edge where busy is low. The predictor sees it at that same edge.
	task automatic send_cmd(input req_t kind, input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start    <= 1'b1;
		req_type <= kind;
		rx_byte  <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.absorb_command(kind, b);
		if (kind != REQ_NONE)
			n_commands++;
	endtask

	// APB write of idle_limit, only once the receiver has gone quiet.
	task automatic write_idle_limit(input logic [7:0] v);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_IDLE_LIMIT, 2'b00};
		pwdata  <= {{(APB_DATA_W-8){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_gap_limit(v);
		cur_limit = v;
		n_settings++;
	endtask

	// Mostly well-formed frames (bytes, enough ticks to close, read) with random
	// payload; the rest is short noise of arbitrary request codes, early reads
	// and frames left open.
	task automatic run_traffic(input int unsigned n_items, input bit allow_gaps);
		int unsigned first;
		int unsigned nb;
		int unsigned nt;
		int unsigned i;
		first = n_commands;
		while (n_commands - first < n_items) begin
			gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) < 7) begin
				nb = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20)
				                                 : $urandom_range(1, 6);
				for (i = 0; i < nb; i++)
					send_cmd(REQ_BYTE, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 4) == 0 && cur_limit != 0)
					nt = $urandom_range(0, cur_limit - 1);     // leave frame open
				else
					nt = cur_limit + $urandom_range(0, 2);
				for (i = 0; i < nt; i++)
					send_cmd(REQ_TICK, 8'($urandom_range(0, 255)));
				send_cmd(REQ_READ, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 5) == 0)
					send_cmd(REQ_READ, 8'($urandom_range(0, 255)));
			end else begin
				nb = $urandom_range(1, 6);
				for (i = 0; i < nb; i++)
					send_cmd(req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		int unsigned i;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset idle limit: read with nothing held, the ignored request
		// code, byte extremes, one tick short of closing (read must not touch the
		// idle count), close, byte appended after completion, read twice.
		gaps_on = 1'b0;
		send_cmd(REQ_READ, 8'h00);
		send_cmd(REQ_BYTE, 8'h00);
		send_cmd(REQ_NONE, 8'hff);
		send_cmd(REQ_BYTE, 8'hff);
		for (i = 0; i < IDLE_LIMIT_RST - 1; i++)
			send_cmd(REQ_TICK, 8'hff);
		send_cmd(REQ_READ, 8'hff);
		send_cmd(REQ_TICK, 8'h00);
		send_cmd(REQ_BYTE, 8'h5a);
		send_cmd(REQ_READ, 8'h00);
		send_cmd(REQ_READ, 8'h00);

		write_idle_limit(8'd1);
		run_traffic(30, 1'b1);

		// zero limit: any tick closes a non-empty frame; also overfill the store
		write_idle_limit(8'd0);
		for (i = 0; i < BUFFER_DEPTH_DEF + 2; i++)
			send_cmd(REQ_BYTE, 8'(i * 37 + 1));
		send_cmd(REQ_TICK, 8'h00);
		send_cmd(REQ_READ, 8'h00);
		run_traffic(20, 1'b1);

		// max limit: a tick run far below the limit, then a read
		write_idle_limit(8'd255);
		send_cmd(REQ_BYTE, 8'ha5);
		for (i = 0; i < 20; i++)
			send_cmd(REQ_TICK, 8'h00);
		send_cmd(REQ_READ, 8'h00);

		write_idle_limit(8'($urandom_range(2, 12)));
		run_traffic(30, 1'b1);

		// closing stretch, back-to-back transactions
		write_idle_limit(8'd3);
		run_traffic(30, 1'b0);

		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d transactions over %0d idle-limit settings: %0d frames read,",
			n_commands, n_settings + 1, sb.n_frames);
		$display("%0d not-ready replies, %0d bytes dropped on a full store, %0d results checked",
			sb.n_not_ready, sb.n_dropped, sb.n_results);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/core/igfr_pkg.sv
rtl/core/igfr_cfg.sv
rtl/core/idle_gap_frame_receiver.sv
verif/tb.sv
